FILE: rtl/core/csremu_pkg.sv
// ----------------------------------------------------------------------------
// csremu_pkg: shared types and constants of the csr instruction emulator
// opcode fields, csr numbers, result codes and transaction structs
// ----------------------------------------------------------------------------
`default_nettype none

package csremu_pkg;

    localparam int INSN_W  = 32;
    localparam int XLEN    = 64;
    localparam int MODE_W  = 2;
    localparam int REG_W   = 5;
    localparam int CNTEN_W = 5;
    localparam int CSR_W   = 12;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] F7_SFENCE  = 7'h09;

    localparam logic [2:0] F3_PRIV   = 3'd0;
    localparam logic [2:0] F3_CSRRW  = 3'd1;
    localparam logic [2:0] F3_CSRRS  = 3'd2;
    localparam logic [2:0] F3_CSRRC  = 3'd3;
    localparam logic [2:0] F3_CSRRWI = 3'd5;
    localparam logic [2:0] F3_CSRRSI = 3'd6;
    localparam logic [2:0] F3_CSRRCI = 3'd7;

    localparam logic [CSR_W-1:0] ADDR_SATP    = 12'h180;
    localparam logic [CSR_W-1:0] ADDR_CYCLE   = 12'hC00;
    localparam logic [CSR_W-1:0] ADDR_TIME    = 12'hC01;
    localparam logic [CSR_W-1:0] ADDR_INSTRET = 12'hC02;
    localparam logic [CSR_W-1:0] ADDR_HPC3    = 12'hB03;
    localparam logic [CSR_W-1:0] ADDR_HPC4    = 12'hB04;
    localparam logic [CSR_W-1:0] ADDR_HPE3    = 12'h323;
    localparam logic [CSR_W-1:0] ADDR_HPE4    = 12'h324;

    localparam logic [MODE_W-1:0] MODE_USER  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUPER = 2'd1;

    localparam logic [CNTEN_W-1:0] CNTEN_ALL   = 5'h1f;
    localparam int                 CNTEN_CY    = 0;
    localparam int                 CNTEN_TM    = 1;
    localparam int                 CNTEN_IR    = 2;
    localparam int                 CNTEN_HPM3  = 3;
    localparam int                 CNTEN_HPM4  = 4;

    localparam logic [3:0] PGMODE_SV39 = 4'h8;

    typedef enum logic [1:0] {
        OUT_DONE    = 2'd0,
        OUT_ILLEGAL = 2'd1,
        OUT_SFENCE  = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        SEL_SATP,
        SEL_CYCLE,
        SEL_INSTRET,
        SEL_HPC3,
        SEL_HPC4,
        SEL_HPE3,
        SEL_HPE4
    } csr_sel_t;

    typedef struct packed {
        logic [INSN_W-1:0] instruction;
        logic [XLEN-1:0]   rs1_value;
        logic [MODE_W-1:0] prev_mode;
        logic [XLEN-1:0]   time_now;
    } item_t;

    typedef struct packed {
        outcome_t         outcome;
        logic             rd_write;
        logic [REG_W-1:0] rd_index;
        logic [XLEN-1:0]  rd_value;
    } result_t;

    typedef struct packed {
        logic [XLEN-1:0] satp;
        logic [XLEN-1:0] cycle;
        logic [XLEN-1:0] instret;
        logic [XLEN-1:0] hpc3;
        logic [XLEN-1:0] hpc4;
        logic [XLEN-1:0] hpe3;
        logic [XLEN-1:0] hpe4;
    } csr_state_t;

    typedef struct packed {
        logic            en;
        csr_sel_t        sel;
        logic [XLEN-1:0] data;
    } csr_wr_t;

endpackage

`default_nettype wire

FILE: rtl/core/csremu_exec.sv
// ----------------------------------------------------------------------------
// csremu_exec: decode and execute of one trapped instruction
// system opcode decode, csr read mux, read-modify-write value and legality
// ----------------------------------------------------------------------------
`default_nettype none

module csremu_exec (
    input  csremu_pkg::item_t      item,
    input  csremu_pkg::csr_state_t csr_state,
    input  wire logic [csremu_pkg::CNTEN_W-1:0] counter_enable,
    output csremu_pkg::result_t    result,
    output csremu_pkg::csr_wr_t    csr_wr
);
    import csremu_pkg::*;

    logic [6:0]       opcode;
    logic [2:0]       funct3;
    logic [6:0]       funct7;
    logic [REG_W-1:0] rs1_num;
    logic [REG_W-1:0] rd_num;
    logic [CSR_W-1:0] csr_num;
    logic [CNTEN_W-1:0] en;
    logic             read_ok;
    logic             write_ok;
    logic             f3_ok;
    logic             wr_needed;
    logic             commit;
    logic [XLEN-1:0]  old_value;
    logic [XLEN-1:0]  new_value;
    logic [XLEN-1:0]  uimm;
    csr_sel_t         sel;

    assign opcode  = item.instruction[6:0];
    assign rd_num  = item.instruction[11:7];
    assign funct3  = item.instruction[14:12];
    assign rs1_num = item.instruction[19:15];
    assign csr_num = item.instruction[31:20];
    assign funct7  = item.instruction[31:25];
    assign uimm    = {{(XLEN-REG_W){1'b0}}, rs1_num};
    assign en      = (item.prev_mode == MODE_USER) ? counter_enable : CNTEN_ALL;

    always_comb begin
        read_ok   = 1'b1;
        write_ok  = 1'b1;
        old_value = '0;
        sel       = SEL_SATP;
        unique case (csr_num)
            ADDR_SATP: begin
                old_value = csr_state.satp;
                write_ok  = (item.prev_mode == MODE_SUPER);
            end
            ADDR_CYCLE: begin
                read_ok   = en[CNTEN_CY];
                old_value = csr_state.cycle;
                sel       = SEL_CYCLE;
            end
            ADDR_TIME: begin
                read_ok   = en[CNTEN_TM];
                old_value = item.time_now;
                write_ok  = 1'b0;
            end
            ADDR_INSTRET: begin
                read_ok   = en[CNTEN_IR];
                old_value = csr_state.instret;
                sel       = SEL_INSTRET;
            end
            ADDR_HPC3: begin
                read_ok   = en[CNTEN_HPM3];
                old_value = csr_state.hpc3;
                sel       = SEL_HPC3;
            end
            ADDR_HPC4: begin
                read_ok   = en[CNTEN_HPM4];
                old_value = csr_state.hpc4;
                sel       = SEL_HPC4;
            end
            ADDR_HPE3: begin
                old_value = csr_state.hpe3;
                sel       = SEL_HPE3;
            end
            ADDR_HPE4: begin
                old_value = csr_state.hpe4;
                sel       = SEL_HPE4;
            end
            default: begin
                read_ok  = 1'b0;
                write_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        f3_ok     = 1'b1;
        wr_needed = (rs1_num != '0);
        new_value = '0;
        unique case (funct3)
            F3_CSRRW: begin
                new_value = item.rs1_value;
                wr_needed = 1'b1;
            end
            F3_CSRRS:  new_value = old_value | item.rs1_value;
            F3_CSRRC:  new_value = old_value & ~item.rs1_value;
            F3_CSRRWI: begin
                new_value = uimm;
                wr_needed = 1'b1;
            end
            F3_CSRRSI: new_value = old_value | uimm;
            F3_CSRRCI: new_value = old_value & ~uimm;
            default:   f3_ok = 1'b0;
        endcase
    end

    assign commit = (opcode == OPC_SYSTEM)
                 && !(funct3 == F3_PRIV && funct7 == F7_SFENCE)
                 && read_ok && f3_ok && (!wr_needed || write_ok);

    always_comb begin
        result         = '0;
        result.outcome = OUT_ILLEGAL;
        priority if (opcode != OPC_SYSTEM) begin
            result.outcome = OUT_ILLEGAL;
        end else if (funct3 == F3_PRIV && funct7 == F7_SFENCE) begin
            result.outcome = (item.prev_mode == MODE_SUPER) ? OUT_SFENCE : OUT_ILLEGAL;
        end else if (commit) begin
            result.outcome  = OUT_DONE;
            result.rd_write = (rd_num != '0);
            result.rd_index = rd_num;
            result.rd_value = (rd_num != '0) ? old_value : '0;
        end else begin
            result.outcome = OUT_ILLEGAL;
        end
    end

    // satp keeps only sv39 values, other writes still count as done
    assign csr_wr.en   = commit && wr_needed
                      && !(sel == SEL_SATP && new_value[XLEN-1:XLEN-4] != PGMODE_SV39);
    assign csr_wr.sel  = sel;
    assign csr_wr.data = new_value;

endmodule

`default_nettype wire

FILE: rtl/core/csr_instruction_emulator.sv
// ----------------------------------------------------------------------------
// csr_instruction_emulator: top level of the trapped csr instruction emulator
// input register, then result register; csr update and result capture share one edge
// throughput: 1 transaction per cycle unless m_tready stalls the result
// reset: aresetn synchronous active low clears csr copies, counter_enable, valids
// ----------------------------------------------------------------------------
`default_nettype none

module csr_instruction_emulator (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [csremu_pkg::CNTEN_W-1:0]     cfg_data,
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    // instruction, rs1_value, prev_mode, time_now, zero pad
    input  wire logic [csremu_pkg::S_TDATA_W-1:0]   s_tdata,
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    // rd_write, rd_index, rd_value, zero pad
    output      logic [csremu_pkg::M_TDATA_W-1:0]   m_tdata,
    // outcome
    output      logic [csremu_pkg::M_TUSER_W-1:0]   m_tuser
);
    import csremu_pkg::*;

    logic               in_valid_reg;
    item_t              in_item_reg;
    logic               out_valid_reg;
    result_t            out_result_reg;
    logic [CNTEN_W-1:0] counter_enable_reg;
    csr_state_t         csr_state_reg;
    csr_state_t         csr_state_next;
    item_t              s_item;
    result_t            result;
    csr_wr_t            csr_wr;
    logic               out_free;
    logic               advance;

    assign s_item.instruction = s_tdata[31:0];
    assign s_item.rs1_value   = s_tdata[95:32];
    assign s_item.prev_mode   = s_tdata[97:96];
    assign s_item.time_now    = s_tdata[161:98];

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    csremu_exec u_exec (
        .item           (in_item_reg),
        .csr_state      (csr_state_reg),
        .counter_enable (counter_enable_reg),
        .result         (result),
        .csr_wr         (csr_wr)
    );

    always_comb begin
        csr_state_next = csr_state_reg;
        if (advance && csr_wr.en) begin
            unique case (csr_wr.sel)
                SEL_SATP:    csr_state_next.satp    = csr_wr.data;
                SEL_CYCLE:   csr_state_next.cycle   = csr_wr.data;
                SEL_INSTRET: csr_state_next.instret = csr_wr.data;
                SEL_HPC3:    csr_state_next.hpc3    = csr_wr.data;
                SEL_HPC4:    csr_state_next.hpc4    = csr_wr.data;
                SEL_HPE3:    csr_state_next.hpe3    = csr_wr.data;
                SEL_HPE4:    csr_state_next.hpe4    = csr_wr.data;
                default:     csr_state_next = csr_state_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            counter_enable_reg <= '0;
            csr_state_reg      <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_valid && cfg_ready) begin
                counter_enable_reg <= cfg_data;
            end
            csr_state_reg <= csr_state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1-REG_W-XLEN){1'b0}}, out_result_reg.rd_value,
                       out_result_reg.rd_index, out_result_reg.rd_write};
    assign m_tuser  = out_result_reg.outcome;

endmodule

`default_nettype wire

FILE: rtl/core/csremu_checker.sv
// ----------------------------------------------------------------------------
// csremu_checker: port-level checks of the csr instruction emulator
// result coding and output hold, attached to the top level by bind
// ----------------------------------------------------------------------------
`default_nettype none

module csremu_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [csremu_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic [csremu_pkg::M_TUSER_W-1:0]   m_tuser
);
    import csremu_pkg::*;

    // only the three defined result codes appear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == OUT_DONE || m_tuser == OUT_ILLEGAL
                      || m_tuser == OUT_SFENCE))
        else $error("csremu: undefined outcome");

    // illegal and sfence results carry no register write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != OUT_DONE) |-> (m_tdata == '0))
        else $error("csremu: non-done result with register data");

    // rd write exactly when destination is not x0
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[REG_W:1] != '0)))
        else $error("csremu: rd_write disagrees with rd_index");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("csremu: stalled result changed");

endmodule

bind csr_instruction_emulator csremu_checker u_csremu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: bench/csr_emu_checker.sv
// ----------------------------------------------------------------------------
// csr_emu_checker: result predictor and comparator for the csr emulator
// watches the config, input and result channels, keeps its own copy of the
// csr shadows and counter enable, and compares every result transaction with
// the oldest predicted one
// ----------------------------------------------------------------------------
module csr_emu_checker
    import csremu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CNTEN_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    output int                   fail_count,
    output int                   pending
);

    localparam int RS1_LSB  = INSN_W;
    localparam int MODE_LSB = RS1_LSB + XLEN;
    localparam int TIME_LSB = MODE_LSB + MODE_W;

    csr_state_t         shadow;
    logic [CNTEN_W-1:0] cnten_q;
    result_t            expected_q[$];

    function automatic logic fetch_csr(input logic [CSR_W-1:0] num,
                                       input logic [MODE_W-1:0] mode,
                                       input logic [XLEN-1:0] now,
                                       output logic [XLEN-1:0] val);
        logic [CNTEN_W-1:0] en;
        en = (mode == MODE_USER) ? cnten_q : CNTEN_ALL;
        val = '0;
        fetch_csr = 1'b1;
        case (num)
            ADDR_SATP:    val = shadow.satp;
            ADDR_CYCLE:   begin val = shadow.cycle;   fetch_csr = en[CNTEN_CY];   end
            ADDR_TIME:    begin val = now;            fetch_csr = en[CNTEN_TM];   end
            ADDR_INSTRET: begin val = shadow.instret; fetch_csr = en[CNTEN_IR];   end
            ADDR_HPC3:    begin val = shadow.hpc3;    fetch_csr = en[CNTEN_HPM3]; end
            ADDR_HPC4:    begin val = shadow.hpc4;    fetch_csr = en[CNTEN_HPM4]; end
            ADDR_HPE3:    val = shadow.hpe3;
            ADDR_HPE4:    val = shadow.hpe4;
            default:      fetch_csr = 1'b0;
        endcase
    endfunction

    function automatic logic store_csr(input logic [CSR_W-1:0] num,
                                       input logic [MODE_W-1:0] mode,
                                       input logic [XLEN-1:0] val);
        store_csr = 1'b1;
        case (num)
            ADDR_SATP: begin
                if (mode != MODE_SUPER)
                    store_csr = 1'b0;
                else if (val[XLEN-1 -: 4] == PGMODE_SV39)
                    shadow.satp = val;
            end
            ADDR_CYCLE:   shadow.cycle = val;
            ADDR_INSTRET: shadow.instret = val;
            ADDR_HPC3:    shadow.hpc3 = val;
            ADDR_HPC4:    shadow.hpc4 = val;
            ADDR_HPE3:    shadow.hpe3 = val;
            ADDR_HPE4:    shadow.hpe4 = val;
            default:      store_csr = 1'b0;
        endcase
    endfunction

    function automatic result_t emulate_insn(input item_t it);
        result_t            r;
        logic [CSR_W-1:0]   num;
        logic [REG_W-1:0]   rs1f;
        logic [REG_W-1:0]   rd;
        logic [2:0]         f3;
        logic [6:0]         f7;
        logic [XLEN-1:0]    old;
        logic [XLEN-1:0]    nv;
        logic [XLEN-1:0]    imm;
        logic               wr;
        r.outcome  = OUT_ILLEGAL;
        r.rd_write = 1'b0;
        r.rd_index = '0;
        r.rd_value = '0;
        num  = it.instruction[31:20];
        f7   = it.instruction[31:25];
        rs1f = it.instruction[19:15];
        f3   = it.instruction[14:12];
        rd   = it.instruction[11:7];
        imm  = {{(XLEN-REG_W){1'b0}}, rs1f};
        wr   = (rs1f != '0);
        nv   = '0;
        if (it.instruction[6:0] != OPC_SYSTEM)
            return r;
        if (f3 == F3_PRIV && f7 == F7_SFENCE) begin
            if (it.prev_mode == MODE_SUPER)
                r.outcome = OUT_SFENCE;
            return r;
        end
        if (!fetch_csr(num, it.prev_mode, it.time_now, old))
            return r;
        case (f3)
            F3_CSRRW:  begin nv = it.rs1_value; wr = 1'b1; end
            F3_CSRRS:  nv = old | it.rs1_value;
            F3_CSRRC:  nv = old & ~it.rs1_value;
            F3_CSRRWI: begin nv = imm; wr = 1'b1; end
            F3_CSRRSI: nv = old | imm;
            F3_CSRRCI: nv = old & ~imm;
            default:   return r;
        endcase
        if (wr && !store_csr(num, it.prev_mode, nv))
            return r;
        r.outcome = OUT_DONE;
        if (rd != '0) begin
            r.rd_write = 1'b1;
            r.rd_index = rd;
            r.rd_value = old;
        end
        return r;
    endfunction

    function automatic item_t unpack_item(input logic [S_TDATA_W-1:0] word);
        item_t it;
        it.instruction = word[0 +: INSN_W];
        it.rs1_value   = word[RS1_LSB +: XLEN];
        it.prev_mode   = word[MODE_LSB +: MODE_W];
        it.time_now    = word[TIME_LSB +: XLEN];
        return it;
    endfunction

    always @(posedge aclk) begin
        result_t          exp;
        logic             got_write;
        logic [REG_W-1:0] got_rd;
        logic [XLEN-1:0]  got_value;
        if (!aresetn) begin
            shadow     = '0;
            cnten_q    = '0;
            fail_count = 0;
            expected_q.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                cnten_q = cfg_data;
            if (m_tvalid && m_tready) begin
                got_write = m_tdata[0];
                got_rd    = m_tdata[1 +: REG_W];
                got_value = m_tdata[1 + REG_W +: XLEN];
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: outcome %0d write %0b rd %0d value %h",
                                 m_tuser, got_write, got_rd, got_value);
                end else begin
                    exp = expected_q.pop_front();
                    if (m_tuser !== exp.outcome || got_write !== exp.rd_write ||
                        got_rd !== exp.rd_index || got_value !== exp.rd_value) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected outcome %0d write %0b rd %0d value %h",
                                     exp.outcome, exp.rd_write, exp.rd_index, exp.rd_value);
                            $display("          got outcome %0d write %0b rd %0d value %h",
                                     m_tuser, got_write, got_rd, got_value);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(emulate_insn(unpack_item(s_tdata)));
            pending <= expected_q.size();
        end
    end

endmodule

FILE: bench/tb_csr_instruction_emulator.sv
// ----------------------------------------------------------------------------
// tb_csr_instruction_emulator: stimulus and verdict for the csr emulator
// directed trapped instructions cover every csr form and each illegal path,
// then random phases under several counter enable settings with bursty input,
// a patterned result stall and long result hold-offs that back up the input
// ----------------------------------------------------------------------------
module tb_csr_instruction_emulator;
    import csremu_pkg::*;

    localparam int RS1_LSB  = INSN_W;
    localparam int MODE_LSB = RS1_LSB + XLEN;
    localparam int TIME_LSB = MODE_LSB + MODE_W;
    localparam int PHASE_ITEMS = 140;

    localparam logic [MODE_W-1:0] MODE_MACH     = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RSVD     = 2'd2;
    localparam logic [2:0]        F3_RSVD       = 3'd4;
    localparam logic [CSR_W-1:0]  ADDR_UNMAPPED = 12'h300;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CNTEN_W-1:0]   cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int fail_count;
    int pending;
    int burst_left = 0;
    int gap_max = 3;
    int squeeze_seq = 0;

    always #5 aclk = ~aclk;

    csr_instruction_emulator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    csr_emu_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic logic [INSN_W-1:0] csr_insn(input logic [2:0] f3,
                                                   input logic [CSR_W-1:0] num,
                                                   input logic [REG_W-1:0] rs1f,
                                                   input logic [REG_W-1:0] rd);
        return {num, rs1f, f3, rd, OPC_SYSTEM};
    endfunction

    function automatic logic [INSN_W-1:0] sfence_insn(input logic [REG_W-1:0] rs2f,
                                                      input logic [REG_W-1:0] rs1f,
                                                      input logic [REG_W-1:0] rd);
        return {F7_SFENCE, rs2f, rs1f, F3_PRIV, rd, OPC_SYSTEM};
    endfunction

    function automatic item_t mk(input logic [INSN_W-1:0] insn, input logic [XLEN-1:0] rs1v,
                                 input logic [MODE_W-1:0] mode, input logic [XLEN-1:0] now);
        item_t it;
        it.instruction = insn;
        it.rs1_value   = rs1v;
        it.prev_mode   = mode;
        it.time_now    = now;
        return it;
    endfunction

    function automatic logic [CSR_W-1:0] pick_csr();
        case ($urandom_range(0, 8))
            0: return ADDR_SATP;
            1: return ADDR_CYCLE;
            2: return ADDR_TIME;
            3: return ADDR_INSTRET;
            4: return ADDR_HPC3;
            5: return ADDR_HPC4;
            6: return ADDR_HPE3;
            7: return ADDR_HPE4;
            default: return CSR_W'($urandom_range(0, (1 << CSR_W) - 1));
        endcase
    endfunction

    function automatic logic [2:0] pick_f3();
        case ($urandom_range(0, 7))
            0: return F3_CSRRW;
            1: return F3_CSRRS;
            2: return F3_CSRRC;
            3: return F3_CSRRWI;
            4: return F3_CSRRSI;
            5: return F3_CSRRCI;
            default: return 3'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic item_t random_item();
        item_t            it;
        int               pick;
        logic [REG_W-1:0] rs1f;
        logic [REG_W-1:0] rd;
        pick = $urandom_range(0, 99);
        it.rs1_value = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0)
            it.rs1_value[XLEN-1 -: 4] = PGMODE_SV39;
        it.time_now  = {$urandom, $urandom};
        it.prev_mode = MODE_W'($urandom_range(0, 3));
        rs1f = ($urandom_range(0, 3) == 0) ? '0 : REG_W'($urandom_range(1, 31));
        rd   = ($urandom_range(0, 7) == 0) ? '0 : REG_W'($urandom_range(1, 31));
        if (pick < 8)
            it.instruction = $urandom;
        else if (pick < 14)
            it.instruction = sfence_insn(REG_W'($urandom_range(0, 31)), rs1f, rd);
        else
            it.instruction = csr_insn(pick_f3(), pick_csr(), rs1f, rd);
        return it;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_item(input item_t it);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[0 +: INSN_W]        = it.instruction;
        word[RS1_LSB +: XLEN]    = it.rs1_value;
        word[MODE_LSB +: MODE_W] = it.prev_mode;
        word[TIME_LSB +: XLEN]   = it.time_now;
        return word;
    endfunction

    task automatic send_insn(input item_t it);
        s_tdata  <= pack_item(it);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (gap_max > 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cnten(input logic [CNTEN_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side stall pattern, with a long hold-off on request
    initial begin : receiver
        int squeeze_seen;
        int stall_kind;
        int span;
        int tick;
        squeeze_seen = 0;
        tick = 0;
        forever begin
            stall_kind = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge aclk);
                tick++;
                if (squeeze_seq != squeeze_seen) begin
                    squeeze_seen = squeeze_seq;
                    m_tready <= 1'b0;
                    repeat (80) @(posedge aclk);
                end
                case (stall_kind)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 9) == 0);
                    default: m_tready <= ((tick % 7) < 4);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [CNTEN_W-1:0] cnten;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_cnten('0);

        // malformed and privileged words
        send_insn(mk(32'h0000_0013, '0, MODE_MACH, '0));
        send_insn(mk('1, '1, MODE_MACH, '1));
        send_insn(mk(sfence_insn(5'd3, 5'd2, 5'd0), '0, MODE_SUPER, '0));
        send_insn(mk(sfence_insn(5'd0, 5'd0, 5'd9), '0, MODE_USER, '0));
        send_insn(mk(sfence_insn(5'd31, 5'd31, 5'd31), '1, MODE_RSVD, '1));
        send_insn(mk(csr_insn(F3_PRIV, ADDR_CYCLE, 5'd1, 5'd1), '0, MODE_MACH, '0));
        send_insn(mk(csr_insn(F3_RSVD, ADDR_CYCLE, 5'd1, 5'd1), '0, MODE_MACH, '0));
        send_insn(mk(csr_insn(F3_CSRRS, ADDR_UNMAPPED, 5'd0, 5'd1), '0, MODE_MACH, '0));
        send_insn(mk(csr_insn(F3_CSRRS, ADDR_CYCLE, 5'd0, 5'd1), '0, MODE_USER, '0));
        // counters and events, each csr form
        send_insn(mk(csr_insn(F3_CSRRW, ADDR_CYCLE, 5'd6, 5'd5), 64'h0123_4567_89ab_cdef,
                     MODE_MACH, '0));
        send_insn(mk(csr_insn(F3_CSRRS, ADDR_CYCLE, 5'd0, 5'd7), '1, MODE_MACH, '0));
        send_insn(mk(csr_insn(F3_CSRRC, ADDR_CYCLE, 5'd3, 5'd0), 64'hffff_0000_0000_0000,
                     MODE_MACH, '0));
        send_insn(mk(csr_insn(F3_CSRRS, ADDR_INSTRET, 5'd31, 5'd31), '1, MODE_SUPER, '0));
        send_insn(mk(csr_insn(F3_CSRRCI, ADDR_INSTRET, 5'd31, 5'd1), '0, MODE_MACH, '0));
        send_insn(mk(csr_insn(F3_CSRRWI, ADDR_HPC3, 5'h15, 5'd2), '0, MODE_MACH, '0));
        send_insn(mk(csr_insn(F3_CSRRSI, ADDR_HPC4, 5'd0, 5'd3), '0, MODE_MACH, '0));
        send_insn(mk(csr_insn(F3_CSRRSI, ADDR_HPE3, 5'h0a, 5'd4), '0, MODE_USER, '0));
        send_insn(mk(csr_insn(F3_CSRRW, ADDR_HPE4, 5'd8, 5'd9), 64'h5a5a_a5a5_f00d_beef,
                     MODE_RSVD, '0));
        // time and satp
        send_insn(mk(csr_insn(F3_CSRRW, ADDR_TIME, 5'd4, 5'd4), '1, MODE_MACH, '1));
        send_insn(mk(csr_insn(F3_CSRRS, ADDR_TIME, 5'd0, 5'd10), '1, MODE_MACH,
                     64'hdead_beef_0000_1234));
        send_insn(mk(csr_insn(F3_CSRRW, ADDR_SATP, 5'd1, 5'd11), 64'h8000_0000_0000_0001,
                     MODE_USER, '0));
        send_insn(mk(csr_insn(F3_CSRRW, ADDR_SATP, 5'd1, 5'd11), 64'h8000_0000_0000_0001,
                     MODE_MACH, '0));
        send_insn(mk(csr_insn(F3_CSRRW, ADDR_SATP, 5'd1, 5'd12), 64'h8000_0000_0001_2345,
                     MODE_SUPER, '0));
        send_insn(mk(csr_insn(F3_CSRRW, ADDR_SATP, 5'd1, 5'd13), 64'h9000_0000_0000_0fff,
                     MODE_SUPER, '0));
        send_insn(mk(csr_insn(F3_CSRRS, ADDR_SATP, 5'd0, 5'd14), '0, MODE_SUPER, '0));
        wait_idle();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin cnten = CNTEN_ALL; gap_max = 3; end
                1: begin cnten = '0; gap_max = 0; end
                2: begin cnten = CNTEN_W'($urandom_range(1, 30)); gap_max = 8; end
                3: begin cnten = CNTEN_W'($urandom_range(1, 30)); gap_max = 2; end
                default: begin cnten = CNTEN_ALL; gap_max = 5; end
            endcase
            write_cnten(cnten);
            if (phase == 1 || phase == 3)
                squeeze_seq <= squeeze_seq + 1;
            repeat (PHASE_ITEMS) send_insn(random_item());
            wait_idle();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
